/* rtl/fse_pkg.sv */
// Shared types, widths and constants for the shape function evaluation pipeline.
// No dependencies; every rtl file refers to it by scoped names.
package fse_pkg;

   localparam int FRAC_BITS = 16;
   localparam int IN_W      = 18;
   localparam int OUT_W     = 20;
   localparam int OPD_W     = 20;
   localparam int PROD_W    = 2 * OPD_W;
   localparam int LIN_W     = 23;
   localparam int RND_W     = PROD_W - FRAC_BITS;
   localparam int SUM_W     = RND_W + 2;
   localparam int NODES     = 6;
   localparam int COUNT_W   = 3;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 2;

   typedef logic signed [OPD_W-1:0]  opd_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [LIN_W-1:0]  lin_type;
   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef logic signed [OUT_W-1:0]  basis_type;

   typedef enum logic [1:0] {
      KIND_P1 = 2'd0,
      KIND_Q1 = 2'd1,
      KIND_P2 = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ACT_VALUE = 2'd0,
      ACT_DXSI  = 2'd1,
      ACT_DETA  = 2'd2
   } action_type;

   localparam logic [CSR_IDX_W-1:0] CSR_ELEMENT_KIND = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPACE_DIM    = 1'd1;

   localparam logic [1:0] DIM_SUPPORTED = 2'd2;
   localparam logic [1:0] DIM_RESET     = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_NONE = 3'd0;
   localparam logic [COUNT_W-1:0] COUNT_P1   = 3'd3;
   localparam logic [COUNT_W-1:0] COUNT_Q1   = 3'd4;
   localparam logic [COUNT_W-1:0] COUNT_P2   = 3'd6;

   localparam opd_type  ONE_OPD    = OPD_W'(2 ** FRAC_BITS);
   localparam lin_type  ONE_LIN    = LIN_W'(2 ** FRAC_BITS);
   localparam prod_type HALF_LIN   = PROD_W'(2 ** (FRAC_BITS - 1));
   localparam prod_type HALF_QUAD  = PROD_W'(2 ** (FRAC_BITS + 1));
   localparam sum_type  SAT_HI     = SUM_W'(2 ** (OUT_W - 1) - 1);
   localparam sum_type  SAT_LO     = SUM_W'(-(2 ** (OUT_W - 1)));

   typedef struct packed {
      logic [COUNT_W-1:0] node_count;
      logic               status;
      logic               quad;
   } ctrl_type;

endpackage

/* rtl/fem_shape_function_eval_core.sv */
// Pipeline: four register stages. Throughput: one point per cycle, held back
// only when rsp_tready stays low and every stage is full. Reset (synchronous,
// active high) empties the pipeline and sets element_kind to the linear triangle
// and space_dimension to 2. Depends on fse_pkg and the fse_ stages.
module fem_shape_function_eval_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [39:0]  req_tdata,   // xsi_coord [17:0], eta_coord [35:18], zero fill
   input  logic [1:0]   req_tuser,   // action [1:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // basis_0..basis_5 [119:0], node_count [122:120], zero fill
   output logic [0:0]   rsp_tuser,   // status [0]
   input  logic                              csr_we,
   input  logic [fse_pkg::CSR_IDX_W-1:0]     csr_addr,
   input  logic [fse_pkg::CSR_DAT_W-1:0]     csr_wdata
);

   logic [1:0] kind_ff, kind_in;
   logic [1:0] dim_ff, dim_in;
   logic       v1_ff, v2_ff, v3_ff, v4_ff;
   logic       rdy1, rdy2, rdy3, rdy4;

   fse_pkg::opd_type   opd_a [fse_pkg::NODES];
   fse_pkg::opd_type   opd_b [fse_pkg::NODES];
   fse_pkg::lin_type   lin_s1 [fse_pkg::NODES];
   fse_pkg::ctrl_type  ctrl_s1;
   fse_pkg::prod_type  prod_s2 [fse_pkg::NODES];
   fse_pkg::lin_type   lin_s2 [fse_pkg::NODES];
   fse_pkg::ctrl_type  ctrl_s2;
   fse_pkg::basis_type basis [fse_pkg::NODES];
   fse_pkg::ctrl_type  ctrl_out;

   always_comb begin
      kind_in = kind_ff;
      dim_in  = dim_ff;
      if (csr_we) begin
         case (csr_addr)
            fse_pkg::CSR_ELEMENT_KIND: kind_in = csr_wdata;
            fse_pkg::CSR_SPACE_DIM:    dim_in  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= fse_pkg::KIND_P1;
         dim_ff  <= fse_pkg::DIM_RESET;
      end else begin
         kind_ff <= kind_in;
         dim_ff  <= dim_in;
      end
   end

   // a stage loads when it is empty or its contents move on
   assign rdy4       = !v4_ff || rsp_tready;
   assign rdy3       = !v3_ff || rdy4;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   fse_operand u_operand (
      .clock           (clock),
      .enable          (rdy1),
      .action          (req_tuser),
      .xsi_coord       ($signed(req_tdata[17:0])),
      .eta_coord       ($signed(req_tdata[35:18])),
      .element_kind    (kind_ff),
      .space_dimension (dim_ff),
      .opd_a_ff        (opd_a),
      .opd_b_ff        (opd_b),
      .lin_ff          (lin_s1),
      .ctrl_ff         (ctrl_s1)
   );

   fse_mult u_mult (
      .clock   (clock),
      .enable  (rdy2),
      .opd_a   (opd_a),
      .opd_b   (opd_b),
      .lin     (lin_s1),
      .ctrl    (ctrl_s1),
      .prod_ff (prod_s2),
      .lin_ff  (lin_s2),
      .ctrl_ff (ctrl_s2)
   );

   fse_finish u_finish (
      .clock      (clock),
      .enable_sum (rdy3),
      .enable_out (rdy4),
      .prod       (prod_s2),
      .lin        (lin_s2),
      .ctrl       (ctrl_s2),
      .basis_ff   (basis),
      .ctrl_ff    (ctrl_out)
   );

   assign rsp_tvalid = v4_ff;
   assign rsp_tuser  = ctrl_out.status;
   assign rsp_tdata  = {5'b0, ctrl_out.node_count,
                        basis[5], basis[4], basis[3], basis[2], basis[1], basis[0]};

   a_error_clears : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |->
         (ctrl_out.node_count == fse_pkg::COUNT_NONE && rsp_tdata[119:0] == '0))
      else $error("error result carries data or a node count");

   a_count_legal : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (ctrl_out.node_count == fse_pkg::COUNT_NONE ||
                      ctrl_out.node_count == fse_pkg::COUNT_P1 ||
                      ctrl_out.node_count == fse_pkg::COUNT_Q1 ||
                      ctrl_out.node_count == fse_pkg::COUNT_P2))
      else $error("node count outside the element set");

   a_unused_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && ctrl_out.node_count == fse_pkg::COUNT_P1) |-> rsp_tdata[119:60] == '0)
      else $error("unused slots of a linear triangle not zero");

   a_full_stalls : assert property (@(posedge clock) disable iff (reset)
      (v1_ff && v2_ff && v3_ff && v4_ff && !rsp_tready) |-> !req_tready)
      else $error("full pipeline takes a transfer while stalled");

   a_advance : assert property (@(posedge clock) disable iff (reset)
      (v1_ff && rdy2) |=> v2_ff)
      else $error("item lost between stage one and stage two");

endmodule

/* rtl/fse_operand.sv */
// Stage one: decodes element kind and action into a multiplier operand pair and
// a linear term per node, or an error status. Depends on fse_pkg.
module fse_operand (
   input  logic                      clock,
   input  logic                      enable,
   input  logic [1:0]                action,
   input  logic signed [fse_pkg::IN_W-1:0] xsi_coord,
   input  logic signed [fse_pkg::IN_W-1:0] eta_coord,
   input  logic [1:0]                element_kind,
   input  logic [1:0]                space_dimension,
   output fse_pkg::opd_type          opd_a_ff [fse_pkg::NODES],
   output fse_pkg::opd_type          opd_b_ff [fse_pkg::NODES],
   output fse_pkg::lin_type          lin_ff [fse_pkg::NODES],
   output fse_pkg::ctrl_type         ctrl_ff
);

   fse_pkg::opd_type  opd_a_in [fse_pkg::NODES];
   fse_pkg::opd_type  opd_b_in [fse_pkg::NODES];
   fse_pkg::lin_type  lin_in [fse_pkg::NODES];
   fse_pkg::ctrl_type ctrl_in;

   always_comb begin
      fse_pkg::opd_type xo, eo, so, xp, xm, ep, em;
      fse_pkg::lin_type xl, el, sl;
      xo = {{(fse_pkg::OPD_W-fse_pkg::IN_W){xsi_coord[fse_pkg::IN_W-1]}}, xsi_coord};
      eo = {{(fse_pkg::OPD_W-fse_pkg::IN_W){eta_coord[fse_pkg::IN_W-1]}}, eta_coord};
      so = xo + eo;
      xp = fse_pkg::ONE_OPD + xo;
      xm = fse_pkg::ONE_OPD - xo;
      ep = fse_pkg::ONE_OPD + eo;
      em = fse_pkg::ONE_OPD - eo;
      xl = {{(fse_pkg::LIN_W-fse_pkg::IN_W){xsi_coord[fse_pkg::IN_W-1]}}, xsi_coord};
      el = {{(fse_pkg::LIN_W-fse_pkg::IN_W){eta_coord[fse_pkg::IN_W-1]}}, eta_coord};
      sl = xl + el;
      for (int i = 0; i < fse_pkg::NODES; i++) begin
         opd_a_in[i] = '0;
         opd_b_in[i] = '0;
         lin_in[i]   = '0;
      end
      ctrl_in.node_count = fse_pkg::COUNT_NONE;
      ctrl_in.status     = 1'b0;
      ctrl_in.quad       = 1'b0;
      if (space_dimension != fse_pkg::DIM_SUPPORTED) begin
         ctrl_in.status = 1'b1;
      end else begin
         case (element_kind)
            fse_pkg::KIND_P1: begin
               ctrl_in.node_count = fse_pkg::COUNT_P1;
               case (action)
                  fse_pkg::ACT_VALUE: begin
                     lin_in[0] = fse_pkg::ONE_LIN - sl;
                     lin_in[1] = xl;
                     lin_in[2] = el;
                  end
                  fse_pkg::ACT_DXSI: begin
                     lin_in[0] = -fse_pkg::ONE_LIN;
                     lin_in[1] = fse_pkg::ONE_LIN;
                  end
                  default: begin
                     lin_in[0] = -fse_pkg::ONE_LIN;
                     lin_in[2] = fse_pkg::ONE_LIN;
                  end
               endcase
            end
            fse_pkg::KIND_Q1: begin
               // every node is a product scaled by a quarter; derivatives swap a
               // factor for plus or minus one
               ctrl_in.node_count = fse_pkg::COUNT_Q1;
               ctrl_in.quad       = 1'b1;
               opd_a_in[0] = xp;
               opd_a_in[1] = xm;
               opd_a_in[2] = xm;
               opd_a_in[3] = xp;
               opd_b_in[0] = ep;
               opd_b_in[1] = ep;
               opd_b_in[2] = em;
               opd_b_in[3] = em;
               case (action)
                  fse_pkg::ACT_VALUE: begin
                  end
                  fse_pkg::ACT_DXSI: begin
                     opd_a_in[0] = fse_pkg::ONE_OPD;
                     opd_a_in[1] = -fse_pkg::ONE_OPD;
                     opd_a_in[2] = -fse_pkg::ONE_OPD;
                     opd_a_in[3] = fse_pkg::ONE_OPD;
                  end
                  default: begin
                     opd_b_in[0] = fse_pkg::ONE_OPD;
                     opd_b_in[1] = fse_pkg::ONE_OPD;
                     opd_b_in[2] = -fse_pkg::ONE_OPD;
                     opd_b_in[3] = -fse_pkg::ONE_OPD;
                  end
               endcase
            end
            fse_pkg::KIND_P2: begin
               ctrl_in.node_count = fse_pkg::COUNT_P2;
               case (action)
                  fse_pkg::ACT_VALUE: begin
                     lin_in[0]   = fse_pkg::ONE_LIN - ((sl <<< 1) + sl);
                     opd_a_in[0] = so <<< 1;
                     opd_b_in[0] = so;
                     opd_a_in[1] = xo;
                     opd_b_in[1] = (xo <<< 1) - fse_pkg::ONE_OPD;
                     opd_a_in[2] = eo;
                     opd_b_in[2] = (eo <<< 1) - fse_pkg::ONE_OPD;
                     opd_a_in[3] = xo <<< 2;
                     opd_b_in[3] = fse_pkg::ONE_OPD - so;
                     opd_a_in[4] = xo <<< 2;
                     opd_b_in[4] = eo;
                     opd_a_in[5] = eo <<< 2;
                     opd_b_in[5] = fse_pkg::ONE_OPD - so;
                  end
                  fse_pkg::ACT_DXSI: begin
                     lin_in[0] = (sl <<< 2) - ((fse_pkg::ONE_LIN <<< 1) + fse_pkg::ONE_LIN);
                     lin_in[1] = (xl <<< 2) - fse_pkg::ONE_LIN;
                     lin_in[3] = (fse_pkg::ONE_LIN <<< 2) - (xl <<< 3) - (el <<< 2);
                     lin_in[4] = el <<< 2;
                     lin_in[5] = -(el <<< 2);
                  end
                  default: begin
                     lin_in[0] = (sl <<< 2) - ((fse_pkg::ONE_LIN <<< 1) + fse_pkg::ONE_LIN);
                     lin_in[2] = (el <<< 2) - fse_pkg::ONE_LIN;
                     lin_in[3] = -(xl <<< 2);
                     lin_in[4] = xl <<< 2;
                     lin_in[5] = (fse_pkg::ONE_LIN <<< 2) - (xl <<< 2) - (el <<< 3);
                  end
               endcase
            end
            default: begin
               ctrl_in.status = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         opd_a_ff <= opd_a_in;
         opd_b_ff <= opd_b_in;
         lin_ff   <= lin_in;
         ctrl_ff  <= ctrl_in;
      end
   end

endmodule

/* rtl/fse_mult.sv */
// Stage two: one signed multiplier per node, linear term and control carried along.
// Depends on fse_pkg.
module fse_mult (
   input  logic              clock,
   input  logic              enable,
   input  fse_pkg::opd_type  opd_a [fse_pkg::NODES],
   input  fse_pkg::opd_type  opd_b [fse_pkg::NODES],
   input  fse_pkg::lin_type  lin [fse_pkg::NODES],
   input  fse_pkg::ctrl_type ctrl,
   output fse_pkg::prod_type prod_ff [fse_pkg::NODES],
   output fse_pkg::lin_type  lin_ff [fse_pkg::NODES],
   output fse_pkg::ctrl_type ctrl_ff
);

   fse_pkg::prod_type prod_in [fse_pkg::NODES];

   always_comb begin
      for (int i = 0; i < fse_pkg::NODES; i++) begin
         prod_in[i] = fse_pkg::PROD_W'(opd_a[i] * opd_b[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
         lin_ff  <= lin;
         ctrl_ff <= ctrl;
      end
   end

endmodule

/* rtl/fse_finish.sv */
// Stages three and four: round each product, add the linear term, then saturate.
// Depends on fse_pkg.
module fse_finish (
   input  logic               clock,
   input  logic               enable_sum,
   input  logic               enable_out,
   input  fse_pkg::prod_type  prod [fse_pkg::NODES],
   input  fse_pkg::lin_type   lin [fse_pkg::NODES],
   input  fse_pkg::ctrl_type  ctrl,
   output fse_pkg::basis_type basis_ff [fse_pkg::NODES],
   output fse_pkg::ctrl_type  ctrl_ff
);

   fse_pkg::sum_type   sum_in [fse_pkg::NODES];
   fse_pkg::sum_type   sum_ff [fse_pkg::NODES];
   fse_pkg::ctrl_type  sum_ctrl_ff;
   fse_pkg::basis_type basis_in [fse_pkg::NODES];

   // add half, then take the high bits: round to nearest, ties upward
   always_comb begin
      fse_pkg::prod_type p_lin, p_quad;
      fse_pkg::sum_type  rnd;
      for (int i = 0; i < fse_pkg::NODES; i++) begin
         p_lin  = prod[i] + fse_pkg::HALF_LIN;
         p_quad = prod[i] + fse_pkg::HALF_QUAD;
         if (ctrl.quad) begin
            rnd = fse_pkg::SUM_W'($signed(p_quad[fse_pkg::PROD_W-1:fse_pkg::FRAC_BITS+2]));
         end else begin
            rnd = fse_pkg::SUM_W'($signed(p_lin[fse_pkg::PROD_W-1:fse_pkg::FRAC_BITS]));
         end
         sum_in[i] = rnd + fse_pkg::SUM_W'(lin[i]);
      end
   end

   always_comb begin
      for (int i = 0; i < fse_pkg::NODES; i++) begin
         if (sum_ff[i] > fse_pkg::SAT_HI) begin
            basis_in[i] = fse_pkg::OUT_W'(fse_pkg::SAT_HI);
         end else if (sum_ff[i] < fse_pkg::SAT_LO) begin
            basis_in[i] = fse_pkg::OUT_W'(fse_pkg::SAT_LO);
         end else begin
            basis_in[i] = sum_ff[i][fse_pkg::OUT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable_sum) begin
         sum_ff      <= sum_in;
         sum_ctrl_ff <= ctrl;
      end
      if (enable_out) begin
         basis_ff <= basis_in;
         ctrl_ff  <= sum_ctrl_ff;
      end
   end

endmodule

/* sim/fem_shape_function_eval_core_tb.sv */
// Self-checking bench for fem_shape_function_eval_core: streams reference points under every
// element kind and dimension setting and checks each basis result against an in-bench predictor.
// Depends on rtl/fse_pkg.sv and the core RTL.
`timescale 1ns / 100ps

module fem_shape_function_eval_core_tb;

   localparam int          CYCLE_LIMIT = 300000;
   localparam int          DRAIN_PAD   = 8;
   localparam longint      ONE         = longint'(1) << fse_pkg::FRAC_BITS;
   localparam longint      OUT_HI      = (longint'(1) << (fse_pkg::OUT_W - 1)) - 1;
   localparam longint      OUT_LO      = -(longint'(1) << (fse_pkg::OUT_W - 1));
   localparam int          COORD_MAX   = (1 << (fse_pkg::IN_W - 1)) - 1;
   localparam int          COORD_MIN   = -(1 << (fse_pkg::IN_W - 1));
   localparam logic [1:0]  KIND_UNDEF  = 2'd3;
   localparam logic [1:0]  ACT_RSVD    = 2'd3;
   localparam logic [1:0]  DIM_NONE    = 2'd0;
   localparam logic [1:0]  DIM_LINE    = 2'd1;
   localparam logic [1:0]  DIM_SOLID   = 2'd3;

   typedef struct packed {
      logic [1:0]               action;
      logic [fse_pkg::IN_W-1:0] eta;
      logic [fse_pkg::IN_W-1:0] xsi;
   } point_type;

   typedef struct packed {
      logic                                         status;
      logic [fse_pkg::COUNT_W-1:0]                  node_count;
      logic [fse_pkg::NODES-1:0][fse_pkg::OUT_W-1:0] basis;
   } shape_result_type;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_COIN,
      RX_SPARSE,
      RX_COMB
   } rx_mode_type;

   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [39:0]                   req_tdata  = '0;   // xsi_coord [17:0], eta_coord [35:18], zero fill
   logic [1:0]                    req_tuser  = '0;   // action [1:0]
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [127:0]                  rsp_tdata;         // basis_0..basis_5 [119:0], node_count [122:120]
   logic [0:0]                    rsp_tuser;         // status [0]
   logic                          csr_we     = 1'b0;
   logic [fse_pkg::CSR_IDX_W-1:0] csr_addr   = '0;
   logic [fse_pkg::CSR_DAT_W-1:0] csr_wdata  = '0;

   point_type        pending_points_q [$];
   shape_result_type basis_due_q [$];
   point_type        cur_point;
   logic [1:0]       kind_cfg = fse_pkg::KIND_P1;
   logic [1:0]       dim_cfg  = fse_pkg::DIM_RESET;
   int               burst_left   = 0;
   int               gap_left     = 0;
   int               stall_left   = 0;
   rx_mode_type      rx_mode      = RX_OPEN;
   int               cycle_cnt    = 0;
   int               accepted_cnt = 0;
   int               checked_cnt  = 0;
   int               err_cnt      = 0;
   int               phase_cnt    = 0;

   fem_shape_function_eval_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // round to nearest, ties toward +infinity: add half, then floor
   function automatic longint round_shift(longint p, int s);
      return (p + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint fix_mul(longint a, longint b);
      return round_shift(a * b, fse_pkg::FRAC_BITS);
   endfunction

   function automatic shape_result_type eval_shape(logic [1:0] kind, logic [1:0] dim,
                                                   point_type pt);
      shape_result_type r;
      longint           v [fse_pkg::NODES];
      longint           x, e, s, c;
      r = '0;
      x = longint'($signed(pt.xsi));
      e = longint'($signed(pt.eta));
      s = x + e;
      for (int i = 0; i < fse_pkg::NODES; i++) v[i] = 0;
      if (dim != fse_pkg::DIM_SUPPORTED || kind == KIND_UNDEF) begin
         r.status = 1'b1;
      end else if (kind == fse_pkg::KIND_P1) begin
         r.node_count = fse_pkg::COUNT_P1;
         if (pt.action == fse_pkg::ACT_VALUE) begin
            v[0] = ONE - s;
            v[1] = x;
            v[2] = e;
         end else begin
            v[0] = -ONE;
            v[1] = (pt.action == fse_pkg::ACT_DXSI) ? ONE : 0;
            v[2] = (pt.action == fse_pkg::ACT_DXSI) ? 0 : ONE;
         end
      end else if (kind == fse_pkg::KIND_Q1) begin
         r.node_count = fse_pkg::COUNT_Q1;
         if (pt.action == fse_pkg::ACT_VALUE) begin
            v[0] = round_shift((ONE + x) * (ONE + e), fse_pkg::FRAC_BITS + 2);
            v[1] = round_shift((ONE - x) * (ONE + e), fse_pkg::FRAC_BITS + 2);
            v[2] = round_shift((ONE - x) * (ONE - e), fse_pkg::FRAC_BITS + 2);
            v[3] = round_shift((ONE + x) * (ONE - e), fse_pkg::FRAC_BITS + 2);
         end else if (pt.action == fse_pkg::ACT_DXSI) begin
            v[0] = round_shift(ONE + e, 2);
            v[1] = round_shift(-ONE - e, 2);
            v[2] = round_shift(-ONE + e, 2);
            v[3] = round_shift(ONE - e, 2);
         end else begin
            v[0] = round_shift(ONE + x, 2);
            v[1] = round_shift(ONE - x, 2);
            v[2] = round_shift(-ONE + x, 2);
            v[3] = round_shift(-ONE - x, 2);
         end
      end else begin
         r.node_count = fse_pkg::COUNT_P2;
         if (pt.action == fse_pkg::ACT_VALUE) begin
            v[0] = ONE - 3 * s + fix_mul(2 * s, s);
            v[1] = fix_mul(x, 2 * x - ONE);
            v[2] = fix_mul(e, 2 * e - ONE);
            v[3] = fix_mul(4 * x, ONE - s);
            v[4] = fix_mul(4 * x, e);
            v[5] = fix_mul(4 * e, ONE - s);
         end else if (pt.action == fse_pkg::ACT_DXSI) begin
            v[0] = -3 * ONE + 4 * s;
            v[1] = 4 * x - ONE;
            v[3] = 4 * ONE - 8 * x - 4 * e;
            v[4] = 4 * e;
            v[5] = -4 * e;
         end else begin
            v[0] = -3 * ONE + 4 * s;
            v[2] = 4 * e - ONE;
            v[3] = -4 * x;
            v[4] = 4 * x;
            v[5] = 4 * ONE - 4 * x - 8 * e;
         end
      end
      for (int i = 0; i < fse_pkg::NODES; i++) begin
         c = v[i];
         if (c > OUT_HI) c = OUT_HI;
         if (c < OUT_LO) c = OUT_LO;
         r.basis[i] = c[fse_pkg::OUT_W-1:0];
      end
      return r;
   endfunction

   // mostly between -1 and 1, some anywhere in the 18-bit range
   function automatic logic [fse_pkg::IN_W-1:0] rand_coord();
      int sel;
      int c;
      sel = $urandom_range(0, 9);
      if (sel < 7)
         c = int'($urandom_range(0, 2 * int'(ONE))) - int'(ONE);
      else if (sel < 9)
         c = int'($urandom);
      else
         case ($urandom_range(0, 3))
            0:       c = int'(ONE);
            1:       c = -int'(ONE);
            2:       c = int'(ONE / 2);
            default: c = 0;
         endcase
      return c[fse_pkg::IN_W-1:0];
   endfunction

   function automatic point_type make_point(logic [1:0] act, int xsi, int eta);
      point_type p;
      p.action = act;
      p.xsi    = xsi[fse_pkg::IN_W-1:0];
      p.eta    = eta[fse_pkg::IN_W-1:0];
      return p;
   endfunction

   // sender: bursts of random length, random gaps, now and then a long unbroken run
   always @(posedge clock) begin : send_p
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            basis_due_q.push_back(eval_shape(kind_cfg, dim_cfg, cur_point));
            accepted_cnt++;
         end
         if (!req_tvalid || req_tready) begin
            if (burst_left == 0) begin
               if ($urandom_range(0, 7) == 0) begin
                  burst_left = $urandom_range(64, 256);
                  gap_left   = 0;
               end else begin
                  burst_left = $urandom_range(1, 16);
                  gap_left   = $urandom_range(0, 6);
               end
            end
            if (gap_left > 0 || pending_points_q.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_tvalid <= 1'b0;
            end else begin
               cur_point = pending_points_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {4'b0, cur_point.eta, cur_point.xsi};
               req_tuser  <= cur_point.action;
               burst_left--;
            end
         end
      end
   end

   // receiver: check each result transfer, stall on a changing pattern
   always @(posedge clock) begin : watch_p
      shape_result_type got;
      shape_result_type want;
      logic             ready_next;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.basis      = rsp_tdata[fse_pkg::NODES*fse_pkg::OUT_W-1:0];
            got.node_count = rsp_tdata[fse_pkg::NODES*fse_pkg::OUT_W +: fse_pkg::COUNT_W];
            got.status     = rsp_tuser[0];
            if (basis_due_q.size() == 0) begin
               err_cnt++;
               $display("%0t: result with nothing expected: status %0d count %0d",
                        $time, got.status, got.node_count);
            end else begin
               want = basis_due_q.pop_front();
               checked_cnt++;
               for (int i = 0; i < fse_pkg::NODES; i++)
                  if (got.basis[i] !== want.basis[i]) begin
                     err_cnt++;
                     $display("%0t: basis_%0d expected %0d got %0d", $time, i,
                              $signed(want.basis[i]), $signed(got.basis[i]));
                  end
               if (got.node_count !== want.node_count) begin
                  err_cnt++;
                  $display("%0t: node_count expected %0d got %0d", $time,
                           want.node_count, got.node_count);
               end
               if (got.status !== want.status) begin
                  err_cnt++;
                  $display("%0t: status expected %0d got %0d", $time,
                           want.status, got.status);
               end
            end
         end
         if (stall_left == 0) begin
            rx_mode    = rx_mode_type'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 160);
         end else begin
            stall_left--;
         end
         case (rx_mode)
            RX_OPEN:   ready_next = 1'b1;
            RX_COIN:   ready_next = 1'($urandom_range(0, 1));
            RX_SPARSE: ready_next = ($urandom_range(0, 7) == 0);
            default:   ready_next = (cycle_cnt % 5) != 0;
         endcase
         rsp_tready <= ready_next;
      end
   end

   always @(posedge clock) begin : limit_p
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("fem_shape_function_eval_core_tb: errors");
         $finish;
      end
   end

   // hold until every queued point is sent and every result has come back
   task automatic drain();
      while (pending_points_q.size() != 0 || req_tvalid || basis_due_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   // both registers are written back to back; caller must be idle
   task automatic set_element(logic [1:0] kind, logic [1:0] dim);
      csr_we    <= 1'b1;
      csr_addr  <= fse_pkg::CSR_ELEMENT_KIND;
      csr_wdata <= kind;
      @(posedge clock);
      csr_addr  <= fse_pkg::CSR_SPACE_DIM;
      csr_wdata <= dim;
      @(posedge clock);
      csr_we    <= 1'b0;
      kind_cfg = kind;
      dim_cfg  = dim;
   endtask

   task automatic run_phase(logic [1:0] kind, logic [1:0] dim, bit do_write, int n_rand,
                            bit corners);
      int ofs;
      if (do_write) set_element(kind, dim);
      if (corners) begin
         // rotate the action so each corner meets three of the four codes over the three kinds
         ofs = phase_cnt;
         pending_points_q.push_back(make_point(2'((0 + ofs) % 4), 0, 0));
         pending_points_q.push_back(make_point(2'((1 + ofs) % 4), int'(ONE), 0));
         pending_points_q.push_back(make_point(2'((2 + ofs) % 4), -int'(ONE), -int'(ONE)));
         pending_points_q.push_back(make_point(2'((3 + ofs) % 4), COORD_MAX, COORD_MAX));
         pending_points_q.push_back(make_point(2'((0 + ofs) % 4), COORD_MIN, COORD_MIN));
         pending_points_q.push_back(make_point(2'((1 + ofs) % 4), COORD_MIN, COORD_MAX));
         // exact rounding ties in the quad and the quadratic triangle
         pending_points_q.push_back(make_point(2'((2 + ofs) % 4), -int'(ONE) + 2, 0));
         pending_points_q.push_back(make_point(2'((3 + ofs) % 4), 2048, 4));
      end
      for (int i = 0; i < n_rand; i++)
         pending_points_q.push_back(
            make_point(2'($urandom_range(fse_pkg::ACT_VALUE, ACT_RSVD)),
                       int'(rand_coord()), int'(rand_coord())));
      phase_cnt++;
      drain();
   endtask

   initial begin : stim_p
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_phase(fse_pkg::KIND_P1, fse_pkg::DIM_RESET,     1'b0, 250, 1'b1);
      run_phase(fse_pkg::KIND_Q1, fse_pkg::DIM_SUPPORTED, 1'b1, 350, 1'b1);
      run_phase(fse_pkg::KIND_P2, fse_pkg::DIM_SUPPORTED, 1'b1, 350, 1'b1);
      run_phase(fse_pkg::KIND_P1, DIM_LINE,               1'b1,  80, 1'b0);
      run_phase(KIND_UNDEF,       fse_pkg::DIM_SUPPORTED, 1'b1, 100, 1'b0);
      run_phase(fse_pkg::KIND_P2, DIM_SOLID,              1'b1,  80, 1'b0);
      run_phase(fse_pkg::KIND_Q1, DIM_NONE,               1'b1,  80, 1'b0);
      run_phase(fse_pkg::KIND_P2, fse_pkg::DIM_SUPPORTED, 1'b1, 300, 1'b0);
      run_phase(fse_pkg::KIND_Q1, fse_pkg::DIM_SUPPORTED, 1'b1, 200, 1'b0);
      run_phase(fse_pkg::KIND_P1, fse_pkg::DIM_SUPPORTED, 1'b1, 100, 1'b0);
      $display("%0d points over %0d element/dimension settings, all four action codes,",
               accepted_cnt, phase_cnt);
      $display("%0d results compared in %0d cycles", checked_cnt, cycle_cnt);
      if (err_cnt == 0)
         $display("fem_shape_function_eval_core_tb: clean");
      else
         $display("fem_shape_function_eval_core_tb: errors");
      $finish;
   end

endmodule
